### sv/price_time_order_book_macros.svh
// assertion macros for the order book
`ifndef PRICE_TIME_ORDER_BOOK_MACROS_SVH
`define PRICE_TIME_ORDER_BOOK_MACROS_SVH

// same-cycle implication, checked out of reset
`define OTB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("order book check failed");

// next-cycle implication, checked out of reset
`define OTB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("order book check failed");

`endif

### sv/otb_pkg.sv
// shared types, codes and ranking function for the order book
package otb_pkg;

    typedef struct packed {
        logic [31:0] price;
        logic [47:0] seq;
        logic [31:0] id;
        logic [31:0] qty;
    } entry_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CANCEL = 2'd1,
        OP_PEEK   = 2'd2,
        OP_POP    = 2'd3
    } opcode_t;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_LIVE   = 2'd1;
    localparam logic [1:0] STAT_BOOK_FULL = 2'd2;
    localparam logic [1:0] STAT_CXL_FULL  = 2'd3;

    typedef enum logic [1:0] {
        BC_HOLD,
        BC_INSERT,
        BC_POP,
        BC_PURGE
    } book_cmd_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EXEC,
        ST_PURGE,
        ST_DONE
    } otb_state_t;

    // true when a ranks strictly ahead of b
    function automatic logic outranks(input logic ask, input entry_t a, input entry_t b);
        logic res;
        if (a.price != b.price) begin
            res = ask ? (a.price < b.price) : (a.price > b.price);
        end else begin
            res = a.seq < b.seq;
        end
        return res;
    endfunction

endpackage

### sv/price_time_order_book.sv
// top level: price-time order book with sticky cancel set
//
//  channel   | valid / ready     | payload
//  ----------+-------------------+-----------------------------------------------
//  request   | s_valid / s_ready | s_opcode s_oid s_side s_price s_quantity ..
//  result    | m_valid / m_ready | m_status m_out_* counts volumes spread
//
// insert, peek and pop pass through the look, exec and done states after accept
// before m_valid rises, and the next word is taken after that; a cancel that adds
// an id also passes through the purge state until both books' sweeps finish,
// as each book's purge sweep moves its head to the tail once per cycle.
// reset is synchronous and active low; it empties both books and the cancel set.
// a stalled result holds in the output register; the next word is taken once
// the current one has been computed and moved there.
`include "price_time_order_book_macros.svh"

module price_time_order_book #(
    parameter int BOOK_DEPTH   = 256,
    parameter int CANCEL_DEPTH = 256,
    localparam int CNT_W       = $clog2(BOOK_DEPTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [31:0]        s_oid,
    input  logic               s_side,
    input  logic [31:0]        s_price,
    input  logic [31:0]        s_quantity,
    input  logic               s_has_seq,
    input  logic [47:0]        s_seq_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [31:0]        m_out_oid,
    output logic               m_out_side,
    output logic [31:0]        m_out_price,
    output logic [31:0]        m_out_quantity,
    output logic [47:0]        m_out_seq,
    output logic [CNT_W-1:0]   m_bid_count,
    output logic [CNT_W-1:0]   m_ask_count,
    output logic [47:0]        m_bid_volume,
    output logic [47:0]        m_ask_volume,
    output logic               m_spread_valid,
    output logic signed [32:0] m_spread
);
    import otb_pkg::*;

    localparam int FILL_W = $clog2(CANCEL_DEPTH + 1);

    otb_state_t  state_reg, state_next;

    opcode_t     op_reg;
    logic [31:0] id_reg;
    logic        side_reg;
    logic [31:0] price_reg;
    logic [31:0] qty_reg;
    logic        has_seq_reg;
    logic [47:0] seq_in_reg;
    logic [47:0] next_seq_reg;

    logic [1:0]  res_status_reg;
    logic [31:0] res_id_reg;
    logic        res_side_reg;
    logic [31:0] res_price_reg;
    logic [31:0] res_qty_reg;
    logic [47:0] res_seq_reg;

    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic [31:0]        m_id_reg;
    logic               m_side_reg;
    logic [31:0]        m_price_reg;
    logic [31:0]        m_qty_reg;
    logic [47:0]        m_seq_reg;
    logic [CNT_W-1:0]   m_bid_cnt_reg;
    logic [CNT_W-1:0]   m_ask_cnt_reg;
    logic [47:0]        m_bid_vol_reg;
    logic [47:0]        m_ask_vol_reg;
    logic               m_spread_valid_reg;
    logic signed [32:0] m_spread_reg;

    book_cmd_t        bid_cmd, ask_cmd;
    entry_t           new_entry;
    entry_t           bid_head, ask_head, side_head;
    logic [CNT_W-1:0] bid_cnt, ask_cnt, side_cnt;
    logic [47:0]      bid_vol, ask_vol;
    logic             bid_busy, ask_busy, bid_full, ask_full, side_full;
    logic             cxl_hit, cxl_full, cxl_add;
    logic             purge_go, out_free, seq_take;
    logic [1:0]       ex_status;
    logic [31:0]      ex_id, ex_price, ex_qty;
    logic             ex_side;
    logic [47:0]      ex_seq;
    logic             spread_ok;
    logic signed [32:0] spread_calc;

    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign side_head = side_reg ? ask_head : bid_head;
    assign side_cnt  = side_reg ? ask_cnt : bid_cnt;
    assign side_full = side_reg ? ask_full : bid_full;
    assign purge_go  = (op_reg == OP_CANCEL) && !cxl_hit && !cxl_full;

    assign new_entry.price = price_reg;
    assign new_entry.seq   = has_seq_reg ? seq_in_reg : next_seq_reg;
    assign new_entry.id    = id_reg;
    assign new_entry.qty   = qty_reg;

    otb_book #(.DEPTH(BOOK_DEPTH), .CW(CNT_W)) u_bid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ask_book  (1'b0),
        .cmd       (bid_cmd),
        .new_entry (new_entry),
        .purge_id  (id_reg),
        .head      (bid_head),
        .count     (bid_cnt),
        .volume    (bid_vol),
        .busy      (bid_busy),
        .full      (bid_full)
    );

    otb_book #(.DEPTH(BOOK_DEPTH), .CW(CNT_W)) u_ask (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ask_book  (1'b1),
        .cmd       (ask_cmd),
        .new_entry (new_entry),
        .purge_id  (id_reg),
        .head      (ask_head),
        .count     (ask_cnt),
        .volume    (ask_vol),
        .busy      (ask_busy),
        .full      (ask_full)
    );

    otb_cxl #(.DEPTH(CANCEL_DEPTH), .FW(FILL_W)) u_cxl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .look_id (id_reg),
        .add     (cxl_add),
        .hit     (cxl_hit),
        .full    (cxl_full)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_EXEC;
            ST_EXEC:  state_next = purge_go ? ST_PURGE : ST_DONE;
            ST_PURGE: if (!bid_busy && !ask_busy) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs and the operation's own result fields
    always_comb begin
        bid_cmd   = BC_HOLD;
        ask_cmd   = BC_HOLD;
        cxl_add   = 1'b0;
        seq_take  = 1'b0;
        ex_status = STAT_OK;
        ex_id     = '0;
        ex_side   = 1'b0;
        ex_price  = '0;
        ex_qty    = '0;
        ex_seq    = '0;
        if (state_reg == ST_EXEC) begin
            unique case (op_reg) inside
                OP_INSERT: begin
                    if (!cxl_hit && side_full) begin
                        ex_status = STAT_BOOK_FULL;
                    end else begin
                        ex_seq   = new_entry.seq;
                        seq_take = !has_seq_reg;
                        // a cancelled id gets its sequence but is never stored
                        if (!cxl_hit) begin
                            if (side_reg) ask_cmd = BC_INSERT;
                            else          bid_cmd = BC_INSERT;
                        end
                    end
                end
                OP_CANCEL: begin
                    if (!cxl_hit) begin
                        if (cxl_full) begin
                            ex_status = STAT_CXL_FULL;
                        end else begin
                            cxl_add = 1'b1;
                            bid_cmd = BC_PURGE;
                            ask_cmd = BC_PURGE;
                        end
                    end
                end
                OP_PEEK, OP_POP: begin
                    if (side_cnt == '0) begin
                        ex_status = STAT_NO_LIVE;
                    end else begin
                        ex_id    = side_head.id;
                        ex_side  = side_reg;
                        ex_price = side_head.price;
                        ex_qty   = side_head.qty;
                        ex_seq   = side_head.seq;
                        if (op_reg == OP_POP) begin
                            if (side_reg) ask_cmd = BC_POP;
                            else          bid_cmd = BC_POP;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign spread_ok   = (bid_cnt != '0) && (ask_cnt != '0);
    assign spread_calc = $signed({1'b0, ask_head.price}) - $signed({1'b0, bid_head.price});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            next_seq_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (seq_take) begin
                next_seq_reg <= next_seq_reg + 1'b1;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg      <= opcode_t'(s_opcode);
            id_reg      <= s_oid;
            side_reg    <= s_side;
            price_reg   <= s_price;
            qty_reg     <= s_quantity;
            has_seq_reg <= s_has_seq;
            seq_in_reg  <= s_seq_in;
        end
        if (state_reg == ST_EXEC) begin
            res_status_reg <= ex_status;
            res_id_reg     <= ex_id;
            res_side_reg   <= ex_side;
            res_price_reg  <= ex_price;
            res_qty_reg    <= ex_qty;
            res_seq_reg    <= ex_seq;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_status_reg       <= res_status_reg;
            m_id_reg           <= res_id_reg;
            m_side_reg         <= res_side_reg;
            m_price_reg        <= res_price_reg;
            m_qty_reg          <= res_qty_reg;
            m_seq_reg          <= res_seq_reg;
            m_bid_cnt_reg      <= bid_cnt;
            m_ask_cnt_reg      <= ask_cnt;
            m_bid_vol_reg      <= bid_vol;
            m_ask_vol_reg      <= ask_vol;
            m_spread_valid_reg <= spread_ok;
            m_spread_reg       <= spread_ok ? spread_calc : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_oid      = m_id_reg;
    assign m_out_side     = m_side_reg;
    assign m_out_price    = m_price_reg;
    assign m_out_quantity = m_qty_reg;
    assign m_out_seq      = m_seq_reg;
    assign m_bid_count    = m_bid_cnt_reg;
    assign m_ask_count    = m_ask_cnt_reg;
    assign m_bid_volume   = m_bid_vol_reg;
    assign m_ask_volume   = m_ask_vol_reg;
    assign m_spread_valid = m_spread_valid_reg;
    assign m_spread       = m_spread_reg;

    `OTB_ASSERT_IMP(a_count_bound, 1'b1, (bid_cnt <= CNT_W'(BOOK_DEPTH)) && (ask_cnt <= CNT_W'(BOOK_DEPTH)))
    `OTB_ASSERT_NXT(a_purge_shrinks, state_reg == ST_PURGE, (bid_cnt <= $past(bid_cnt)) && (ask_cnt <= $past(ask_cnt)))
    `OTB_ASSERT_IMP(a_idle_on_accept, s_valid && s_ready, !bid_busy && !ask_busy)
    `OTB_ASSERT_IMP(a_spread_flag, m_valid, m_spread_valid == ((m_bid_count != '0) && (m_ask_count != '0)))

endmodule

### sv/otb_cell.sv
// one cell of the sorted book chain
module otb_cell (
    input  logic              aclk,
    input  otb_pkg::cell_op_t op,
    input  logic              ask_book,
    input  logic              beyond,
    input  logic              is_tail,
    input  logic              prev_beats,
    input  otb_pkg::entry_t   new_entry,
    input  otb_pkg::entry_t   prev_entry,
    input  otb_pkg::entry_t   next_entry,
    input  otb_pkg::entry_t   tail_entry,
    output otb_pkg::entry_t   entry,
    output logic              beats
);
    import otb_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // an empty cell always yields to the incoming order
    assign beats = beyond || outranks(ask_book, new_entry, entry_reg);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        case (op)
            CELL_INSERT: begin
                if (beats) begin
                    entry_next = prev_beats ? prev_entry : new_entry;
                end
            end
            CELL_SHIFT:  entry_next = next_entry;
            CELL_ROTATE: entry_next = is_tail ? tail_entry : next_entry;
            default:     entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

### sv/otb_book.sv
// one side of the book: sorted cell chain with count, volume and purge sweep
module otb_book #(
    parameter int DEPTH = 256,
    parameter int CW    = 9
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               ask_book,
    input  otb_pkg::book_cmd_t cmd,
    input  otb_pkg::entry_t    new_entry,
    input  logic [31:0]        purge_id,
    output otb_pkg::entry_t    head,
    output logic [CW-1:0]      count,
    output logic [47:0]        volume,
    output logic               busy,
    output logic               full
);
    import otb_pkg::*;

    logic [CW-1:0] count_reg, count_next;
    logic [47:0]   vol_reg, vol_next;
    logic [CW-1:0] rem_reg, rem_next;
    cell_op_t      cell_op;
    logic          drop;
    entry_t        cell_q [DEPTH];
    logic          beats  [DEPTH];

    assign head   = cell_q[0];
    assign count  = count_reg;
    assign volume = vol_reg;
    assign busy   = (rem_reg != '0);
    assign full   = (count_reg == CW'(DEPTH));
    assign drop   = busy && (cell_q[0].id == purge_id);

    always_comb begin
        if (busy) begin
            cell_op = CELL_ROTATE;
        end else begin
            case (cmd)
                BC_INSERT: cell_op = CELL_INSERT;
                BC_POP:    cell_op = CELL_SHIFT;
                default:   cell_op = CELL_HOLD;
            endcase
        end
    end

    // purge: the head leaves each cycle and rejoins at the tail unless it matches
    always_comb begin
        count_next = count_reg;
        vol_next   = vol_reg;
        rem_next   = '0;
        if (busy) begin
            rem_next = rem_reg - 1'b1;
            if (drop) begin
                count_next = count_reg - 1'b1;
                vol_next   = vol_reg - {16'd0, cell_q[0].qty};
            end
        end else begin
            case (cmd)
                BC_INSERT: begin
                    count_next = count_reg + 1'b1;
                    vol_next   = vol_reg + {16'd0, new_entry.qty};
                end
                BC_POP: begin
                    count_next = count_reg - 1'b1;
                    vol_next   = vol_reg - {16'd0, cell_q[0].qty};
                end
                BC_PURGE: rem_next = count_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            vol_reg   <= '0;
            rem_reg   <= '0;
        end else begin
            count_reg <= count_next;
            vol_reg   <= vol_next;
            rem_reg   <= rem_next;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic   prev_b;
        entry_t prev_e;
        entry_t next_e;
        if (i == 0) begin : g_first
            assign prev_b = 1'b0;
            assign prev_e = new_entry;
        end else begin : g_mid
            assign prev_b = beats[i-1];
            assign prev_e = cell_q[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign next_e = cell_q[i];
        end else begin : g_inner
            assign next_e = cell_q[i+1];
        end
        otb_cell u_cell (
            .aclk       (aclk),
            .op         (cell_op),
            .ask_book   (ask_book),
            .beyond     (CW'(i) >= count_reg),
            .is_tail    (CW'(i) == count_reg - 1'b1),
            .prev_beats (prev_b),
            .new_entry  (new_entry),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .tail_entry (cell_q[0]),
            .entry      (cell_q[i]),
            .beats      (beats[i])
        );
    end

endmodule

### sv/otb_cxl.sv
// sticky cancel set: row of id cells with parallel match
module otb_cxl #(
    parameter int DEPTH = 256,
    parameter int FW    = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] look_id,
    input  logic        add,
    output logic        hit,
    output logic        full
);
    logic [FW-1:0]    fill_reg, fill_next;
    logic             hit_reg;
    logic [31:0]      id_q  [DEPTH];
    logic [DEPTH-1:0] match;

    assign full      = (fill_reg == FW'(DEPTH));
    assign hit       = hit_reg;
    assign fill_next = add ? fill_reg + 1'b1 : fill_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_id
        assign match[i] = (FW'(i) < fill_reg) && (id_q[i] == look_id);
        always_ff @(posedge aclk) begin
            if (add && fill_reg == FW'(i)) begin
                id_q[i] <= look_id;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            hit_reg  <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            hit_reg  <= |match;
        end
    end

endmodule
